### rtl/kbsh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbsh_pkg
// Shared types, constants and mixer helpers for the keyed byte stream hash.
// ----------------------------------------------------------------------------
package kbsh_pkg;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);
  localparam int unsigned DIV_CW = $clog2(HASH_W);

  localparam logic [HASH_W-1:0] MIX_MUL_A = 32'h7feb352d;
  localparam logic [HASH_W-1:0] MIX_MUL_B = 32'h846ca68b;

  typedef enum logic [1:0] {
    REQ_STR_BYTE = 2'd0,
    REQ_EMPTY    = 2'd1,
    REQ_INT_KEY  = 2'd2,
    REQ_IDENT    = 2'd3
  } kbsh_req_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL_A,
    F_MUL_B
  } kbsh_fstate_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } kbsh_bstate_t;

  typedef struct packed {
    logic full;
    logic empty;
  } kbsh_qstat_t;

  // First and last xor-shift steps of the mixer.
  function automatic logic [HASH_W-1:0] xs16(input logic [HASH_W-1:0] x);
    xs16 = x ^ (x >> 16);
  endfunction

  function automatic logic [HASH_W-1:0] xs15(input logic [HASH_W-1:0] x);
    xs15 = x ^ (x >> 15);
  endfunction

endpackage : kbsh_pkg
`default_nettype wire

### rtl/kbsh_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbsh_fifo
// Short queue of finished hashes between the mixer front and the reduction back.
// ----------------------------------------------------------------------------
module kbsh_fifo
  import kbsh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [HASH_W-1:0] push_data,
  input  wire logic              pop,
  output logic      [HASH_W-1:0] pop_data,
  output kbsh_qstat_t            qstat
);

  logic [HASH_W-1:0] mem_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]    cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign qstat.full  = (cnt_r == QCW'(QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : kbsh_fifo
`default_nettype wire

### rtl/kbsh_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbsh_front
// Accepts request beats, classifies them and runs the shift-xor-multiply mixer.
// ----------------------------------------------------------------------------
module kbsh_front
  import kbsh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_req_type,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_last_byte,
  input  wire logic signed [63:0] in_key_word,
  input  wire kbsh_qstat_t       qstat,
  output logic                   push,
  output logic      [HASH_W-1:0] push_data
);

  kbsh_fstate_t      state_r, state_nxt;
  logic [HASH_W-1:0] run_hash_r, run_hash_nxt;
  logic [HASH_W-1:0] x_r, x_nxt;
  logic              str_r, str_nxt;
  logic              last_r, last_nxt;
  logic [HASH_W-1:0] pre;
  logic [HASH_W-1:0] z;
  logic [HASH_W-1:0] prod;
  logic [HASH_W-1:0] h;
  kbsh_req_t         req;

  assign in_stall = (state_r != F_IDLE) || qstat.full;
  assign req      = kbsh_req_t'(in_req_type);

  always_comb begin
    state_nxt    = state_r;
    run_hash_nxt = run_hash_r;
    x_nxt        = x_r;
    str_nxt      = str_r;
    last_nxt     = last_r;
    push         = 1'b0;
    push_data    = '0;
    pre          = '0;
    z            = '0;
    prod         = '0;
    h            = '0;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid && !in_stall) begin
          str_nxt  = (req == REQ_STR_BYTE);
          last_nxt = in_last_byte;
          unique case (req)
            REQ_STR_BYTE: pre = (run_hash_r << 5) - run_hash_r + HASH_W'(in_data_byte);
            REQ_EMPTY:    pre = '0;
            REQ_INT_KEY:  pre = in_key_word[31:0] ^ in_key_word[63:32];
            REQ_IDENT:    pre = in_key_word[31:0];
          endcase
          if (req == REQ_EMPTY) begin
            // An empty string reports zero straight away.
            push = 1'b1;
          end else begin
            x_nxt     = xs16(pre);
            state_nxt = F_MUL_A;
          end
        end
      end
      F_MUL_A: begin
        x_nxt     = x_r * MIX_MUL_A;
        state_nxt = F_MUL_B;
      end
      F_MUL_B: begin
        z    = xs15(x_r);
        prod = z * MIX_MUL_B;
        h    = xs16(prod);
        if (str_r) begin
          if (last_r) begin
            run_hash_nxt = '0;
            push         = 1'b1;
            push_data    = h;
          end else begin
            run_hash_nxt = h;
          end
        end else begin
          push      = 1'b1;
          push_data = h;
        end
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      run_hash_r <= '0;
    end else begin
      state_r    <= state_nxt;
      run_hash_r <= run_hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    str_r  <= str_nxt;
    last_r <= last_nxt;
  end

endmodule : kbsh_front
`default_nettype wire

### rtl/kbsh_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbsh_back
// Reduces queued hashes by a nonzero modulus (zero passes them through),
// one quotient bit per cycle, and holds the result in the output register.
// ----------------------------------------------------------------------------
module kbsh_back
  import kbsh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [HASH_W-1:0] modulus,
  input  wire kbsh_qstat_t       qstat,
  input  wire logic [HASH_W-1:0] pop_data,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [HASH_W-1:0] out_hash_value
);

  kbsh_bstate_t      state_r, state_nxt;
  logic [HASH_W-1:0] rem_r, rem_nxt;
  logic [HASH_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [HASH_W-1:0] out_hash_r, out_hash_nxt;
  logic              slot_free;
  logic [HASH_W:0]   shifted;
  logic [HASH_W:0]   trial;

  assign slot_free      = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    cnt_nxt       = cnt_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && out_stall;
    pop           = 1'b0;
    shifted       = {rem_r, dvd_r[HASH_W-1]};
    trial         = shifted - {1'b0, modulus};
    unique case (state_r)
      B_IDLE: begin
        if (!qstat.empty) begin
          pop     = 1'b1;
          cnt_nxt = '0;
          if (modulus == '0) begin
            rem_nxt   = pop_data;
            state_nxt = B_DONE;
          end else begin
            rem_nxt   = '0;
            dvd_nxt   = pop_data;
            state_nxt = B_DIV;
          end
        end
      end
      B_DIV: begin
        // Restoring step: keep the trial difference when it did not borrow.
        rem_nxt = trial[HASH_W] ? shifted[HASH_W-1:0] : trial[HASH_W-1:0];
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(HASH_W - 1)) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = rem_r;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    out_hash_r <= out_hash_nxt;
  end

endmodule : kbsh_back
`default_nettype wire

### rtl/keyed_byte_stream_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_byte_stream_hash
// Hashes string bytes, integer keys and identity words to 32 bits with a
// shift-xor-multiply mixer, with an optional reduction by a modulus.
// ----------------------------------------------------------------------------
// Usage:
// Request beats enter on the in_ channel (valid/stall). A string key is sent
// as a run of string-byte beats, the final one flagged by in_last_byte; only
// that final beat produces a result. Empty-string, integer-key and identity
// beats each produce one result. Result beats leave on the out_ channel
// (valid/stall) in request order.
// The front mixer takes one beat at a time through accept and two
// registered multiplies; an empty string is done at accept. Its rate is set
// by the running hash recurrence: each byte needs the previous mixed value.
// The back reduction pops a hash, runs 32 restoring divider steps unless
// the modulus is zero, and loads the output register. A two-entry queue
// between the two lets the mixer keep accepting while a reduction runs.
// The modulus must be written on the cfg_ channel (always ready) only
// while idle; the block itself does not enforce this.
// Reset (synchronous, rst_n low) clears the running hash, the modulus, the
// queue and the output valid flag. While out_stall is high the result beat
// holds; the back and then the queue fill, and in_stall rises.
// ----------------------------------------------------------------------------
module keyed_byte_stream_hash
  import kbsh_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_last_byte,
  input  wire logic signed [63:0] in_key_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [31:0]        out_hash_value,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [31:0]        cfg_modulus
);

  logic [HASH_W-1:0] modulus_r;
  logic              push;
  logic [HASH_W-1:0] push_data;
  logic              pop;
  logic [HASH_W-1:0] pop_data;
  kbsh_qstat_t       qstat;

  // The modulus register accepts a write beat in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      modulus_r <= cfg_modulus;
    end
  end

  // Front: classifies each beat, folds the key and runs the mixer.
  kbsh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_key_word  (in_key_word),
    .qstat        (qstat),
    .push         (push),
    .push_data    (push_data)
  );

  // Queue of finished hashes waiting for reduction.
  kbsh_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  // Back: modulus reduction and the output register.
  kbsh_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .modulus        (modulus_r),
    .qstat          (qstat),
    .pop_data       (pop_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

endmodule : keyed_byte_stream_hash
`default_nettype wire

### bench/tb_keyed_byte_stream_hash.sv
// ----------------------------------------------------------------------------
// tb_keyed_byte_stream_hash
// Self-checking bench for the keyed byte stream hash. A clocked driver feeds
// request beats from a queue, a clocked monitor checks every result beat
// against a hash worked out here at the moment each request is accepted.
// ----------------------------------------------------------------------------
module tb_keyed_byte_stream_hash;
  timeunit 1ns;
  timeprecision 1ps;

  import kbsh_pkg::*;

  // The mixer constants are kept here so that the prediction does not lean
  // on anything inside the design.
  localparam logic [31:0] MUL_FIRST  = 32'h7feb352d;
  localparam logic [31:0] MUL_SECOND = 32'h846ca68b;
  localparam logic [31:0] STR_MUL    = 32'd31;

  localparam int HALF_PERIOD = 2;
  localparam int IDLE_PCT    = 37;
  localparam int STALL_PCT   = 37;
  // Longest correct gap between handshakes is a full reduction plus random
  // output stalls, so this limit leaves a wide margin.
  localparam int QUIET_LIMIT = 4000;
  // A string byte with no result may still be in the mixer when the last
  // result arrives; this covers it and the back stage with room to spare.
  localparam int SETTLE      = 80;
  localparam int PHASE_BEATS = 250;
  localparam int MAX_PRINTS  = 40;

  typedef struct packed {
    kbsh_req_t   kind;
    logic [7:0]  dbyte;
    logic        last;
    logic [63:0] word;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = REQ_STR_BYTE;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic [63:0] in_key_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_hash_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_modulus = '0;

  // Beats waiting to be driven, and hashes waiting to come out, oldest first.
  beat_t       beats_to_send[$];
  logic [31:0] due_hashes[$];

  // Our own copy of the block's state and its modulus register.
  logic [31:0] string_acc = '0;
  logic [31:0] mod_copy = '0;

  // When set, neither side idles; the stimulus turns it on for one phase.
  logic steady = 1'b0;

  int errors = 0;
  int quiet_cycles = 0;
  int bytes_seen = 0;
  int strings_done = 0;
  int int_keys = 0;
  int ident_words = 0;
  int empties = 0;
  int hashes_checked = 0;
  int cfg_writes = 0;

  keyed_byte_stream_hash dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .in_key_word    (in_key_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_modulus    (cfg_modulus)
  );

  always begin
    #HALF_PERIOD clk = ~clk;
  end

  // Shift-xor-multiply finalizer, all arithmetic modulo 2^32.
  function automatic logic [31:0] lowbias_mix(input logic [31:0] x);
    logic [31:0] v;
    v = x ^ (x >> 16);
    v = v * MUL_FIRST;
    v = v ^ (v >> 15);
    v = v * MUL_SECOND;
    v = v ^ (v >> 16);
    return v;
  endfunction

  // Works out what one accepted beat does to the running hash and which
  // hash, if any, it must produce. The reduction uses the modulus in force
  // when the beat is accepted.
  task automatic hash_beat(input kbsh_req_t kind, input logic [7:0] dbyte,
                           input logic last, input logic [63:0] word);
    logic [31:0] h;
    logic        emits;
    emits = 1'b1;
    h = '0;
    case (kind)
      REQ_STR_BYTE: begin
        string_acc = lowbias_mix(string_acc * STR_MUL + {24'd0, dbyte});
        bytes_seen++;
        emits = last;
        h = string_acc;
        if (last) begin
          string_acc = '0;
          strings_done++;
        end
      end
      REQ_EMPTY: begin
        // An empty string hashes to zero and leaves a string in progress alone.
        empties++;
      end
      REQ_INT_KEY: begin
        h = lowbias_mix(word[31:0] ^ word[63:32]);
        int_keys++;
      end
      default: begin
        h = lowbias_mix(word[31:0]);
        ident_words++;
      end
    endcase
    if (emits) begin
      due_hashes.push_back((mod_copy == '0) ? h : h % mod_copy);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < MAX_PRINTS) begin
      $display("%0t mismatch: %s, got %08h, expected %08h", $realtime, what, got, want);
    end
    errors++;
  endtask

  function automatic beat_t make_beat(input kbsh_req_t kind, input logic [7:0] dbyte,
                                      input logic last, input logic [63:0] word);
    beat_t b;
    b.kind = kind;
    b.dbyte = dbyte;
    b.last = last;
    b.word = word;
    return b;
  endfunction

  // Integer keys lean on the signed extremes, zero and all ones now and then, otherwise random.
  function automatic logic [63:0] rand_word();
    case ($urandom_range(7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return 64'h0;
      3: return 64'hffff_ffff_ffff_ffff;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // A beat of any kind other than a string byte, with junk in unused fields.
  function automatic beat_t rand_keyed_beat();
    kbsh_req_t kind;
    kind = kbsh_req_t'($urandom_range(REQ_EMPTY, REQ_IDENT));
    return make_beat(kind, 8'($urandom), 1'($urandom), rand_word());
  endfunction

  // Mostly whole strings with random bytes, some with other keys slipped in
  // between their bytes; the rest is single keys and loose string bytes.
  task automatic push_random(input int count);
    int made;
    int len;
    int i;
    int pick;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(11) == 0) begin
            beats_to_send.push_back(rand_keyed_beat());
            made++;
          end
          beats_to_send.push_back(make_beat(REQ_STR_BYTE, 8'($urandom), i == len - 1,
                                            rand_word()));
          made++;
        end
      end else if (pick < 92) begin
        beats_to_send.push_back(rand_keyed_beat());
        made++;
      end else begin
        // Loose bytes break strings at random points.
        beats_to_send.push_back(make_beat(REQ_STR_BYTE, 8'($urandom), 1'($urandom),
                                          rand_word()));
        made++;
      end
    end
  endtask

  // Holds the thread until nothing is queued, in flight or expected, and
  // then lets the block finish any silent string byte it is still mixing.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (beats_to_send.size() != 0 || in_valid || due_hashes.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_modulus(input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_modulus <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    mod_copy = value;
    cfg_writes++;
  endtask

  // Driver: a beat stays on the port until it is taken; only then, or when
  // the port is empty, may the next one go out or an idle cycle be spent.
  always @(posedge clk) begin : drive_beats
    beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        hash_beat(kbsh_req_t'(in_req_type), in_data_byte, in_last_byte, in_key_word);
      end
      if (!in_valid || !in_stall) begin
        if (beats_to_send.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = beats_to_send.pop_front();
          in_valid <= 1'b1;
          in_req_type <= nxt.kind;
          in_data_byte <= nxt.dbyte;
          in_last_byte <= nxt.last;
          in_key_word <= nxt.word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest expected hash,
  // stalls the result channel at random and watches for a hang.
  always @(posedge clk) begin : check_hashes
    logic [31:0] want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_valid && !out_stall) begin
        if (due_hashes.size() == 0) begin
          report_mismatch("hash beat with none expected", out_hash_value, '0);
        end else begin
          want = due_hashes.pop_front();
          hashes_checked++;
          if (out_hash_value !== want) begin
            report_mismatch("hash_value", out_hash_value, want);
          end
        end
      end
      out_stall <= !steady && ($urandom_range(99) < STALL_PCT);
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d hashes outstanding",
                 quiet_cycles, due_hashes.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [31:0] moduli[7];
    int p;
    moduli = '{32'hffff_ffff, 32'd1, 32'd7, $urandom, 32'h8000_0000, 32'd0, 32'd1000003};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats under the reset modulus of zero: every request kind,
    // the signed extremes of the integer key, identity words with junk in
    // the high half, single-byte strings at both byte extremes, and keys of
    // every other kind landing in the middle of a string.
    beats_to_send.push_back(make_beat(REQ_EMPTY, 8'hff, 1'b1, 64'hffff_ffff_ffff_ffff));
    beats_to_send.push_back(make_beat(REQ_INT_KEY, 8'h00, 1'b0, 64'h0));
    beats_to_send.push_back(make_beat(REQ_INT_KEY, 8'h00, 1'b0, 64'h8000_0000_0000_0000));
    beats_to_send.push_back(make_beat(REQ_INT_KEY, 8'hff, 1'b1, 64'h7fff_ffff_ffff_ffff));
    beats_to_send.push_back(make_beat(REQ_INT_KEY, 8'h5a, 1'b0, 64'hffff_ffff_ffff_ffff));
    beats_to_send.push_back(make_beat(REQ_INT_KEY, 8'h00, 1'b1, 64'h1234_5678_9abc_def0));
    beats_to_send.push_back(make_beat(REQ_IDENT, 8'hff, 1'b1, 64'hffff_ffff_0000_0000));
    beats_to_send.push_back(make_beat(REQ_IDENT, 8'h00, 1'b0, 64'h0000_0000_ffff_ffff));
    beats_to_send.push_back(make_beat(REQ_STR_BYTE, 8'h00, 1'b1, 64'hffff_ffff_ffff_ffff));
    beats_to_send.push_back(make_beat(REQ_STR_BYTE, 8'hff, 1'b1, 64'h0));
    beats_to_send.push_back(make_beat(REQ_STR_BYTE, "a", 1'b0, 64'h0));
    beats_to_send.push_back(make_beat(REQ_STR_BYTE, "b", 1'b0, 64'h0));
    beats_to_send.push_back(make_beat(REQ_STR_BYTE, "c", 1'b1, 64'h0));
    beats_to_send.push_back(make_beat(REQ_STR_BYTE, "x", 1'b0, 64'h0));
    beats_to_send.push_back(make_beat(REQ_INT_KEY, 8'h77, 1'b1, 64'hdead_beef_cafe_f00d));
    beats_to_send.push_back(make_beat(REQ_STR_BYTE, "y", 1'b0, 64'h0));
    beats_to_send.push_back(make_beat(REQ_IDENT, 8'h33, 1'b1, 64'h0123_4567_89ab_cdef));
    beats_to_send.push_back(make_beat(REQ_EMPTY, 8'h00, 1'b0, 64'h0));
    beats_to_send.push_back(make_beat(REQ_STR_BYTE, "z", 1'b1, 64'h0));
    beats_to_send.push_back(make_beat(REQ_STR_BYTE, 8'h80, 1'b0, 64'h0));
    beats_to_send.push_back(make_beat(REQ_STR_BYTE, 8'h7f, 1'b1, 64'h0));
    wait_idle();

    // Random phases, each under its own modulus, extremes included. Halfway
    // through each phase the sender holds off until every hash is back.
    for (p = 0; p < 7; p++) begin
      write_modulus(moduli[p]);
      @(negedge clk);
      steady = (p == 3);
      push_random(PHASE_BEATS / 2);
      wait_idle();
      push_random(PHASE_BEATS - PHASE_BEATS / 2);
      wait_idle();
      steady = 1'b0;
    end

    $display("covered %0d string bytes in %0d strings, %0d integer keys, %0d identity words,",
             bytes_seen, strings_done, int_keys, ident_words);
    $display("%0d empty strings; %0d hashes checked across %0d modulus writes, %0d errors",
             empties, hashes_checked, cfg_writes, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
